@@ hdl/rarp_pkg.sv @@
// ----------------------------------------------------------------------------
// rarp_pkg
// Shared types and constants for the randomized aligned region placer.
// ----------------------------------------------------------------------------
`default_nettype none

package rarp_pkg;

    // Field widths
    localparam int ADDR_W   = 48;
    localparam int WIDE_W   = 50;   // internal address math with carry room
    localparam int SAMPLE_W = 64;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int ALOG_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Parameter defaults
    localparam int MAP_PAGES_DEF   = 4096;
    localparam int PROBE_LIMIT_DEF = 256;
    localparam int PAGE_BYTES_DEF  = 4096;

    // Register reset values
    localparam logic [ADDR_W-1:0] WIN_BEGIN_RST = 48'd0;
    localparam logic [ADDR_W-1:0] WIN_END_RST   = 48'd16777216;
    localparam logic [ALOG_W-1:0] ALOG_RST      = 5'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_BEGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALOG      = 2'd2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_MARK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_IMAGE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REGION = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOFREE  = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISP, S_SET2, S_SET3, S_DIVI, S_DIV,
        S_CAND1, S_CAND2, S_CHK1, S_CHK2, S_RD, S_TEST, S_NEXT, S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_LOAD, OP_MARK, OP_SET1, OP_SET2, OP_SET3,
        OP_INVALID, OP_DIV_INIT, OP_DIV_STEP, OP_CAND1, OP_CAND2, OP_CHK1,
        OP_CHK2, OP_RD, OP_ADV, OP_FOUND, OP_NEXT, OP_NOFREE, OP_EMIT
    } t_op;

    // Controller to datapath
    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_mark;
        logic req_ok;
        logic div_last;
        logic span_ok;
        logic page_busy;
        logic last_page;
        logic tries_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hdl/rarp_dp.sv @@
// ----------------------------------------------------------------------------
// rarp_dp
// Datapath: configuration registers, occupancy map memory, setup math,
// bit-serial remainder unit, probe registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rarp_dp #(
    parameter int MAP_PAGES   = rarp_pkg::MAP_PAGES_DEF,
    parameter int PROBE_LIMIT = rarp_pkg::PROBE_LIMIT_DEF,
    parameter int PAGE_BYTES  = rarp_pkg::PAGE_BYTES_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [rarp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [rarp_pkg::ADDR_W-1:0]           i_cfg_data,
    input  wire  [rarp_pkg::CMD_W-1:0]            i_cmd,
    input  wire  [rarp_pkg::ADDR_W-1:0]           i_page_address,
    input  wire  [rarp_pkg::ADDR_W-1:0]           i_image_low,
    input  wire  [rarp_pkg::ADDR_W-1:0]           i_image_high,
    input  wire  [rarp_pkg::ADDR_W-1:0]           i_region_size,
    input  wire  [rarp_pkg::SAMPLE_W-1:0]         i_random_sample,
    input  wire                                   i_out_ready,
    input  rarp_pkg::t_dp_cmd                     i_dcmd,
    output rarp_pkg::t_dp_stat                    o_dstat,
    output logic                                  o_out_valid,
    output logic [rarp_pkg::STAT_W-1:0]           o_status,
    output logic [rarp_pkg::ADDR_W-1:0]           o_placed_start
);
    import rarp_pkg::*;

    localparam int PL = $clog2(PAGE_BYTES);
    localparam int MW = $clog2(MAP_PAGES);
    localparam int TW = $clog2(PROBE_LIMIT + 1);
    localparam int BW = $clog2(SAMPLE_W);
    localparam logic [WIDE_W-1:0] PMASK = WIDE_W'(PAGE_BYTES - 1);
    localparam logic [WIDE_W-1:0] NPAGES = WIDE_W'(MAP_PAGES);

    // Configuration registers
    logic [ADDR_W-1:0] r_wb, r_we;
    logic [ALOG_W-1:0] r_alog;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb   <= WIN_BEGIN_RST;
            r_we   <= WIN_END_RST;
            r_alog <= ALOG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIN_BEGIN: r_wb   <= i_cfg_data;
                CFG_WIN_END:   r_we   <= i_cfg_data;
                CFG_ALOG:      r_alog <= i_cfg_data[ALOG_W-1:0];
                default: ;
            endcase
        end
    end

    // Derived window values
    logic [WIDE_W-1:0] wb, we, amask, base;
    assign wb    = WIDE_W'(r_wb);
    assign we    = WIDE_W'(r_we);
    assign amask = (WIDE_W'(1) << r_alog) - WIDE_W'(1);
    assign base  = wb & ~PMASK;

    // Captured request
    logic [CMD_W-1:0]    r_cmd;
    logic [WIDE_W-1:0]   r_pa, r_low, r_high, r_size;
    logic [SAMPLE_W-1:0] r_sample;

    // Setup and probe registers
    logic              r_img, r_ok;
    logic [WIDE_W-1:0] r_t, r_off, r_span, r_first, r_last, r_diff, r_pages;
    logic [WIDE_W-1:0] r_count, r_rem, r_cand, r_start, r_kfull;
    logic              r_kok;
    logic [BW-1:0]     r_bit;
    logic [TW-1:0]     r_tries;
    logic [MW-1:0]     r_pg;
    logic [MW:0]       r_left;
    logic [MW-1:0]     r_clr;
    logic              r_rdata;
    logic [STAT_W-1:0] r_res_st;
    logic [ADDR_W-1:0] r_res_start;
    logic              r_ov;
    logic [STAT_W-1:0] r_ost;
    logic [ADDR_W-1:0] r_ostart;

    // Combinational helpers
    logic [WIDE_W-1:0] mk_kfull, rem_sh, rem_inc, cnt_n, cand_off, start_off;
    logic              mk_ok;
    assign start_off = r_start - base;
    assign mk_kfull  = (r_pa - base) >> PL;
    assign mk_ok     = (r_pa >= base) && (mk_kfull < NPAGES);
    assign rem_sh    = {r_rem[WIDE_W-2:0], r_sample[SAMPLE_W-1]};
    assign rem_inc   = r_rem + WIDE_W'(1);
    assign cnt_n     = r_diff + WIDE_W'(1);
    assign cand_off  = r_rem << r_alog;

    // Occupancy map
    logic          mem [MAP_PAGES];
    logic          mem_we, mem_wd;
    logic [MW-1:0] mem_wa;

    always_comb begin
        mem_we = 1'b0;
        mem_wd = 1'b0;
        mem_wa = r_clr;
        if (i_dcmd.op == OP_CLR) begin
            mem_we = 1'b1;
        end else if (i_dcmd.op == OP_MARK) begin
            mem_we = mk_ok;
            mem_wd = (r_cmd == CMD_MARK);
            mem_wa = mk_kfull[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_dcmd.op == OP_RD) begin
            r_rdata <= mem[r_pg];
        end
    end

    // Clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_dcmd.op == OP_CLR) begin
            r_clr <= r_clr + MW'(1);
        end
    end

    // Request datapath
    always_ff @(posedge i_clk) begin
        case (i_dcmd.op)
            OP_LOAD: begin
                r_cmd    <= i_cmd;
                r_pa     <= WIDE_W'(i_page_address);
                r_low    <= WIDE_W'(i_image_low);
                r_high   <= WIDE_W'(i_image_high);
                r_size   <= WIDE_W'(i_region_size);
                r_sample <= i_random_sample;
            end
            OP_MARK: begin
                r_res_st    <= mk_ok ? ST_OK : ST_INVALID;
                r_res_start <= '0;
            end
            OP_SET1: begin
                r_img <= (r_cmd == CMD_IMAGE);
                if (r_cmd == CMD_IMAGE) begin
                    r_t    <= (wb > r_low) ? wb - r_low : '0;
                    r_off  <= r_low;
                    r_span <= r_high - r_low;
                    r_ok   <= (r_low < r_high) && ((r_low & PMASK) == '0) &&
                              ((r_high & PMASK) == '0) && (r_high <= we);
                end else begin
                    r_t    <= wb;
                    r_off  <= '0;
                    r_span <= (r_size + PMASK) & ~PMASK;
                    r_ok   <= (r_size != '0) && (wb < we);
                end
            end
            OP_SET2: begin
                r_first <= (r_t + amask) & ~amask;
                r_last  <= (we - (r_img ? r_high : r_span)) & ~amask;
                r_pages <= r_span >> PL;
                if (!r_img && (r_span > we - wb)) begin
                    r_ok <= 1'b0;
                end
            end
            OP_SET3: begin
                if (r_first > r_last) begin
                    r_ok <= 1'b0;
                end
                r_diff <= (r_last - r_first) >> r_alog;
            end
            OP_INVALID: begin
                r_res_st    <= ST_INVALID;
                r_res_start <= '0;
            end
            OP_DIV_INIT: begin
                r_count <= cnt_n;
                r_rem   <= '0;
                r_bit   <= '0;
                r_tries <= (cnt_n < WIDE_W'(PROBE_LIMIT)) ? cnt_n[TW-1:0]
                                                          : TW'(PROBE_LIMIT);
            end
            OP_DIV_STEP: begin
                // one restoring step per sample bit, MSB first
                r_rem    <= (rem_sh >= r_count) ? rem_sh - r_count : rem_sh;
                r_sample <= r_sample << 1;
                r_bit    <= r_bit + BW'(1);
            end
            OP_CAND1: r_cand  <= r_first + cand_off;
            OP_CAND2: r_start <= r_cand + r_off;
            OP_CHK1: begin
                r_kok   <= ((r_start & PMASK) == '0) && (r_start >= base);
                r_kfull <= start_off >> PL;
            end
            OP_CHK2: begin
                r_pg   <= r_kfull[MW-1:0];
                r_left <= r_pages[MW:0];
            end
            OP_ADV: begin
                r_pg   <= r_pg + MW'(1);
                r_left <= r_left - (MW+1)'(1);
            end
            OP_FOUND: begin
                r_res_st    <= ST_OK;
                r_res_start <= r_cand[ADDR_W-1:0];
            end
            OP_NEXT: begin
                r_tries <= r_tries - TW'(1);
                r_rem   <= (rem_inc == r_count) ? '0 : rem_inc;
            end
            OP_NOFREE: begin
                r_res_st    <= ST_NOFREE;
                r_res_start <= '0;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_dcmd.op == OP_EMIT) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dcmd.op == OP_EMIT) begin
            r_ost    <= r_res_st;
            r_ostart <= r_res_start;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_ost;
    assign o_placed_start = r_ostart;

    // Status to controller
    always_comb begin
        o_dstat.clr_last   = (r_clr == MW'(MAP_PAGES - 1));
        o_dstat.is_mark    = (r_cmd == CMD_MARK) || (r_cmd == CMD_CLEAR);
        o_dstat.req_ok     = r_ok;
        o_dstat.div_last   = (r_bit == BW'(SAMPLE_W - 1));
        o_dstat.span_ok    = r_kok && (r_kfull < NPAGES) &&
                             (r_pages + r_kfull <= NPAGES);
        o_dstat.page_busy  = r_rdata;
        o_dstat.last_page  = (r_left == (MW+1)'(1));
        o_dstat.tries_last = (r_tries == TW'(1));
        o_dstat.out_free   = !r_ov || i_out_ready;
    end

endmodule

`default_nettype wire

@@ hdl/rarp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rarp_ctrl
// Controller: sequences map clearing, request setup, remainder and probing.
// ----------------------------------------------------------------------------
`default_nettype none

module rarp_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  rarp_pkg::t_dp_stat  i_dstat,
    output logic                o_in_ready,
    output rarp_pkg::t_dp_cmd   o_dcmd
);
    import rarp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_dstat.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_DISP;
            S_DISP:  n_state = i_dstat.is_mark ? S_EMIT : S_SET2;
            S_SET2:  n_state = S_SET3;
            S_SET3:  n_state = S_DIVI;
            S_DIVI:  n_state = i_dstat.req_ok ? S_DIV : S_EMIT;
            S_DIV:   if (i_dstat.div_last) n_state = S_CAND1;
            S_CAND1: n_state = S_CAND2;
            S_CAND2: n_state = S_CHK1;
            S_CHK1:  n_state = S_CHK2;
            S_CHK2:  n_state = i_dstat.span_ok ? S_RD : S_NEXT;
            S_RD:    n_state = S_TEST;
            S_TEST: begin
                if (i_dstat.page_busy) n_state = S_NEXT;
                else if (i_dstat.last_page) n_state = S_EMIT;
                else n_state = S_RD;
            end
            S_NEXT:  n_state = i_dstat.tries_last ? S_EMIT : S_CAND1;
            S_EMIT:  if (i_dstat.out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_dcmd.op  = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_dcmd.op = OP_CLR;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_dcmd.op = OP_LOAD;
            end
            S_DISP:  o_dcmd.op = i_dstat.is_mark ? OP_MARK : OP_SET1;
            S_SET2:  o_dcmd.op = OP_SET2;
            S_SET3:  o_dcmd.op = OP_SET3;
            S_DIVI:  o_dcmd.op = i_dstat.req_ok ? OP_DIV_INIT : OP_INVALID;
            S_DIV:   o_dcmd.op = OP_DIV_STEP;
            S_CAND1: o_dcmd.op = OP_CAND1;
            S_CAND2: o_dcmd.op = OP_CAND2;
            S_CHK1:  o_dcmd.op = OP_CHK1;
            S_CHK2:  if (i_dstat.span_ok) o_dcmd.op = OP_CHK2;
            S_RD:    o_dcmd.op = OP_RD;
            S_TEST: begin
                if (!i_dstat.page_busy) begin
                    o_dcmd.op = i_dstat.last_page ? OP_FOUND : OP_ADV;
                end
            end
            S_NEXT:  o_dcmd.op = i_dstat.tries_last ? OP_NOFREE : OP_NEXT;
            S_EMIT:  if (i_dstat.out_free) o_dcmd.op = OP_EMIT;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/randomized_aligned_region_placer_top.sv @@
// Flow: a mark/clear writes the map and emits its result; a rejected placement
// emits after setup; a placement runs setup and the 64-step remainder, then probes
// candidates (one map bit read per page), at most min(count, PROBE_LIMIT)
// candidates, and then emits its result.
// Throughput: one transfer in flight; the next is taken once the result is in
// the output register. Reset (sync, active low) clears the map.
// ----------------------------------------------------------------------------
// randomized_aligned_region_placer_top
// Places images and regions at randomized aligned positions in a window
// tracked by a page occupancy map.
// ----------------------------------------------------------------------------
`default_nettype none

module randomized_aligned_region_placer_top #(
    parameter int MAP_PAGES   = rarp_pkg::MAP_PAGES_DEF,
    parameter int PROBE_LIMIT = rarp_pkg::PROBE_LIMIT_DEF,
    parameter int PAGE_BYTES  = rarp_pkg::PAGE_BYTES_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [rarp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [rarp_pkg::ADDR_W-1:0]    i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [rarp_pkg::CMD_W-1:0]     i_cmd,
    input  wire  [rarp_pkg::ADDR_W-1:0]    i_page_address,
    input  wire  [rarp_pkg::ADDR_W-1:0]    i_image_low,
    input  wire  [rarp_pkg::ADDR_W-1:0]    i_image_high,
    input  wire  [rarp_pkg::ADDR_W-1:0]    i_region_size,
    input  wire  [rarp_pkg::SAMPLE_W-1:0]  i_random_sample,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [rarp_pkg::STAT_W-1:0]    o_status,
    output logic [rarp_pkg::ADDR_W-1:0]    o_placed_start
);
    import rarp_pkg::*;

    t_dp_cmd  dcmd;
    t_dp_stat dstat;

    rarp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_dstat    (dstat),
        .o_in_ready (o_in_ready),
        .o_dcmd     (dcmd)
    );

    rarp_dp #(
        .MAP_PAGES   (MAP_PAGES),
        .PROBE_LIMIT (PROBE_LIMIT),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_page_address  (i_page_address),
        .i_image_low     (i_image_low),
        .i_image_high    (i_image_high),
        .i_region_size   (i_region_size),
        .i_random_sample (i_random_sample),
        .i_out_ready     (i_out_ready),
        .i_dcmd          (dcmd),
        .o_dstat         (dstat),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_placed_start  (o_placed_start)
    );

endmodule

`default_nettype wire

@@ hdl/rarp_checker.sv @@
// ----------------------------------------------------------------------------
// rarp_checker
// Port-level checks for the placer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rarp_props (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_in_valid,
    input wire                            o_in_ready,
    input wire                            o_out_valid,
    input wire                            i_out_ready,
    input wire [rarp_pkg::STAT_W-1:0]     o_status,
    input wire [rarp_pkg::ADDR_W-1:0]     o_placed_start
);
    import rarp_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
        $stable(o_placed_start))
        else $error("stalled result changed");

    // Status code is always a defined one
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_INVALID ||
        o_status == ST_NOFREE))
        else $error("undefined status code");

    // Only successful placements carry a nonzero start
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_placed_start == '0)
        else $error("nonzero start on failed request");

    // One request at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transfer taken while busy");

    // Reset leaves no result pending and blocks input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("reset did not clear handshake");

endmodule

bind randomized_aligned_region_placer_top rarp_props u_rarp_props (.*);

`default_nettype wire
